### rtl/mf3_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// mf3_pkg
// Shared constants and types of the 3x3 mode filter: pixel, column and row
// widths, register indexes and the item descriptor passed from front to back.
// ============================================================================
package mf3_pkg;

   localparam int MAX_WIDTH      = 4096;
   localparam int PIXEL_BITS     = 10;
   localparam int CFG_BITS       = 13;
   localparam int ROW_BITS       = 13;
   localparam int DIM_BITS       = CFG_BITS + 1;
   localparam int COL_BITS       = $clog2(MAX_WIDTH);
   localparam int HEIGHT_CAP     = 8190;
   localparam int WIDTH_RESET    = 3840;
   localparam int HEIGHT_RESET   = 2160;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
   localparam int WIN_TAPS       = 9;
   localparam int CNT_BITS       = $clog2(WIN_TAPS + 1);
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 1'd1;

   typedef logic [PIXEL_BITS-1:0] pixel_type;
   typedef logic [COL_BITS-1:0]   col_type;
   typedef logic [ROW_BITS-1:0]   row_type;
   typedef logic [CFG_BITS-1:0]   cfg_type;
   typedef logic [DIM_BITS-1:0]   dim_type;

   // one classified item on its way to the back end
   typedef struct packed {
      pixel_type pixel;
      col_type   col;
      logic      emit;
      logic      last;
      logic      top_mid;
      logic      bot_mid;
      logic      left_mid;
      logic      right_mid;
   } desc_type;

endpackage

### rtl/mf3_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// mf3_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is issued.
// ============================================================================
module mf3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/mf3_front.sv
`timescale 1ns / 1ps
// ============================================================================
// mf3_front
// Front end: frame size registers, raster position counters and the
// classification of each accepted item (emit, last, edge clamping, window
// column selection) into a descriptor for the back end.
// ============================================================================
module mf3_front import mf3_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  cfg_type                   csr_wr_data,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  pixel_type                 req_pixel_value,
   input  logic                      req_is_flush,
   output logic                      push_valid,
   input  logic                      push_ready,
   output desc_type                  push_desc
);

   cfg_type width_ff, height_ff;
   col_type col_ff, col_in;
   row_type row_ff, row_in;

   dim_type wc, hc, hp1, row1, row2, r, col3;
   col_type col1, col2;
   logic    wrap, restart, emit, last, accept;

   always_comb begin
      if (width_ff == '0) begin
         wc = DIM_BITS'(1);
      end else if (DIM_BITS'(width_ff) > DIM_BITS'(MAX_WIDTH)) begin
         wc = DIM_BITS'(MAX_WIDTH);
      end else begin
         wc = DIM_BITS'(width_ff);
      end
      if (height_ff == '0) begin
         hc = DIM_BITS'(1);
      end else if (DIM_BITS'(height_ff) > DIM_BITS'(HEIGHT_CAP)) begin
         hc = DIM_BITS'(HEIGHT_CAP);
      end else begin
         hc = DIM_BITS'(height_ff);
      end
      hp1 = hc + DIM_BITS'(1);

      // column beyond a narrowed width moves to the next row
      wrap = DIM_BITS'(col_ff) >= wc;
      col1 = wrap ? '0 : col_ff;
      row1 = DIM_BITS'(row_ff) + DIM_BITS'(wrap);

      // position beyond the drain of the frame restarts the frame
      restart = (row1 > hp1) || ((row1 == hp1) && (col1 != '0));
      col2    = restart ? '0 : col1;
      row2    = restart ? '0 : row1;

      emit = ((row2 >= DIM_BITS'(2)) || ((row2 == DIM_BITS'(1)) && (col2 != '0)))
          && ((row2 < hp1) || ((row2 == hp1) && (col2 == '0)));
      last = emit && (row2 == hp1) && (col2 == '0);

      if (col2 == '0) begin
         r = (row2 >= DIM_BITS'(2)) ? row2 - DIM_BITS'(2) : '0;
      end else begin
         r = (row2 == '0) ? '0 : row2 - DIM_BITS'(1);
      end

      push_desc.pixel     = req_is_flush ? '0 : req_pixel_value;
      push_desc.col       = col2;
      push_desc.emit      = emit;
      push_desc.last      = last;
      push_desc.top_mid   = (r == '0);
      push_desc.bot_mid   = (r + DIM_BITS'(1)) >= hc;
      push_desc.left_mid  = (col2 == '0) ? (wc == DIM_BITS'(1)) : (col2 == COL_BITS'(1));
      push_desc.right_mid = (col2 == '0);

      col3 = DIM_BITS'(col2) + DIM_BITS'(1);
      if (last) begin
         col_in = '0;
         row_in = '0;
      end else if (col3 >= wc) begin
         col_in = '0;
         row_in = ROW_BITS'(row2 + DIM_BITS'(1));
      end else begin
         col_in = col3[COL_BITS-1:0];
         row_in = row2[ROW_BITS-1:0];
      end
   end

   assign accept     = req_valid && push_ready;
   assign req_ready  = push_ready;
   assign push_valid = req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_BITS'(WIDTH_RESET);
         height_ff <= CFG_BITS'(HEIGHT_RESET);
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_FRAME_WIDTH:  width_ff  <= csr_wr_data;
               CSR_FRAME_HEIGHT: height_ff <= csr_wr_data;
            endcase
         end
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

endmodule

### rtl/mf3_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// mf3_queue
// Short descriptor queue between front and back, so that either side can
// stall without stopping the other at once.
// ============================================================================
module mf3_queue import mf3_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  desc_type push_desc,
   output logic     pop_valid,
   input  logic     pop_ready,
   output desc_type pop_desc
);

   desc_type              entries_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_BITS:0]    count_ff;
   logic                  push_fire, pop_fire;

   assign push_ready = count_ff != (QPTR_BITS + 1)'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_desc   = entries_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entries_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_fire) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                       : wr_ptr_ff + QPTR_BITS'(1);
         end
         if (pop_fire) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                       : rd_ptr_ff + QPTR_BITS'(1);
         end
         count_ff <= count_ff + (QPTR_BITS + 1)'(push_fire) - (QPTR_BITS + 1)'(pop_fire);
      end
   end

endmodule

### rtl/mf3_back.sv
`timescale 1ns / 1ps
// ============================================================================
// mf3_back
// Back end: line RAM read and update, 3x3 window shift with edge clamping,
// then a three-stage mode pipeline (taps, counts, best pick) into the
// output register.
// ============================================================================
module mf3_back import mf3_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      pop_valid,
   output logic      pop_ready,
   input  desc_type  pop_desc,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output pixel_type rsp_mode_value,
   output logic      rsp_last_of_frame
);

   typedef struct packed {
      logic [CNT_BITS-1:0] cnt;
      pixel_type           val;
   } cand_type;

   function automatic cand_type pick(cand_type x, cand_type y);
      logic take_y;
      take_y = (y.cnt > x.cnt) || ((y.cnt == x.cnt) && (y.val < x.val));
      return take_y ? y : x;
   endfunction

   logic adv, pop_fire, ram_wr_en;
   logic [2*PIXEL_BITS-1:0] ram_rd_data, ram_wr_data, pair, last_wr_ff;

   logic     s1_valid_ff, s1_fwd_ff;
   desc_type s1_desc_ff;

   pixel_type win_ff [3][3];
   pixel_type wp     [3][3];
   pixel_type colv   [3][3];
   pixel_type newcol [3];
   pixel_type tap    [WIN_TAPS];

   pixel_type s2_tap_ff [WIN_TAPS];
   logic      s2_emit_ff, s2_last_ff;

   logic [CNT_BITS-1:0] cnt    [WIN_TAPS];
   logic [CNT_BITS-1:0] s3_cnt_ff [WIN_TAPS];
   pixel_type           s3_val_ff [WIN_TAPS];
   logic                s3_emit_ff, s3_last_ff;

   cand_type cand [WIN_TAPS];
   cand_type lvl1 [4];
   cand_type lvl2 [2];
   cand_type lvl3, best;

   logic      rsp_valid_ff, rsp_last_ff;
   pixel_type rsp_mode_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign pop_ready = adv;
   assign pop_fire  = pop_valid && adv;

   mf3_ram #(
      .WIDTH (2 * PIXEL_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_desc_ff.col),
      .wr_data (ram_wr_data),
      .rd_en   (pop_fire),
      .rd_addr (pop_desc.col),
      .rd_data (ram_rd_data)
   );

   // same column written by the item ahead in the cycle of the read
   assign pair        = s1_fwd_ff ? last_wr_ff : ram_rd_data;
   assign ram_wr_en   = adv && s1_valid_ff;
   assign ram_wr_data = {pair[PIXEL_BITS-1:0], s1_desc_ff.pixel};

   always_comb begin
      newcol[0] = pair[2*PIXEL_BITS-1:PIXEL_BITS];
      newcol[1] = pair[PIXEL_BITS-1:0];
      newcol[2] = s1_desc_ff.pixel;
      for (int i = 0; i < 3; i++) begin
         wp[i][0] = win_ff[i][1];
         wp[i][1] = win_ff[i][2];
         wp[i][2] = newcol[i];
      end
      for (int i = 0; i < 3; i++) begin
         colv[0][i] = s1_desc_ff.left_mid  ? wp[i][1] : wp[i][0];
         colv[1][i] = wp[i][1];
         colv[2][i] = s1_desc_ff.right_mid ? wp[i][1] : wp[i][2];
      end
      for (int k = 0; k < 3; k++) begin
         tap[k]     = s1_desc_ff.top_mid ? colv[k][1] : colv[k][0];
         tap[3 + k] = colv[k][1];
         tap[6 + k] = s1_desc_ff.bot_mid ? colv[k][1] : colv[k][2];
      end
   end

   always_comb begin
      for (int i = 0; i < WIN_TAPS; i++) begin
         logic [WIN_TAPS-1:0] match;
         for (int j = 0; j < WIN_TAPS; j++) begin
            match[j] = s2_tap_ff[j] == s2_tap_ff[i];
         end
         cnt[i] = CNT_BITS'($countones(match));
      end
   end

   always_comb begin
      for (int i = 0; i < WIN_TAPS; i++) begin
         cand[i].cnt = s3_cnt_ff[i];
         cand[i].val = s3_val_ff[i];
      end
      for (int i = 0; i < 4; i++) begin
         lvl1[i] = pick(cand[2 * i], cand[2 * i + 1]);
      end
      for (int i = 0; i < 2; i++) begin
         lvl2[i] = pick(lvl1[2 * i], lvl1[2 * i + 1]);
      end
      lvl3 = pick(lvl2[0], lvl2[1]);
      best = pick(lvl3, cand[WIN_TAPS - 1]);
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (pop_fire) begin
         s1_desc_ff <= pop_desc;
         s1_fwd_ff  <= s1_valid_ff && (s1_desc_ff.col == pop_desc.col);
      end
      if (ram_wr_en) begin
         last_wr_ff <= ram_wr_data;
      end
      if (adv) begin
         s2_tap_ff  <= tap;
         s2_last_ff <= s1_desc_ff.last;
         s3_cnt_ff  <= cnt;
         s3_val_ff  <= s2_tap_ff;
         s3_last_ff <= s2_last_ff;
         rsp_mode_ff <= best.val;
         rsp_last_ff <= s3_last_ff;
      end
   end

   // control and window state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_emit_ff   <= 1'b0;
         s3_emit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (adv) begin
         s1_valid_ff  <= pop_valid;
         s2_emit_ff   <= s1_valid_ff && s1_desc_ff.emit;
         s3_emit_ff   <= s2_emit_ff;
         rsp_valid_ff <= s3_emit_ff;
         if (s1_valid_ff) begin
            win_ff <= wp;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mode_value    = rsp_mode_ff;
   assign rsp_last_of_frame = rsp_last_ff;

endmodule

### rtl/mode_filter_3x3_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// mode_filter_3x3_unit
// Streaming 3x3 mode filter for 10-bit luma in raster order, edge pixels
// repeated at the frame border, smallest value winning a tie.
// ============================================================================
// The unit takes one item per clock and returns one result per clock in
// steady flow. Each result is the mode of the window around the pixel
// accepted w+1 items earlier (w = frame_width), so after the frame w+1 flush
// items drain the last row; the result of the final pixel carries
// last_of_frame and the next item starts a new frame. From acceptance an
// item passes the descriptor queue, the line RAM read (4096 x 20 bits, one
// read and one write per clock), the window stage, the count stage and the
// pick stage into the output register. A result held by the output stalls
// the back end, the two-entry queue then fills and holds the input. The
// line RAM needs no clearing pass: its contents only reach a result once
// written within the frame. Program frame_width and frame_height while no
// item is in flight.
// ============================================================================
module mode_filter_3x3_unit import mf3_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  cfg_type                   csr_wr_data,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  pixel_type                 req_pixel_value,
   input  logic                      req_is_flush,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output pixel_type                 rsp_mode_value,
   output logic                      rsp_last_of_frame
);

   logic     push_valid, push_ready, pop_valid, pop_ready;
   desc_type push_desc, pop_desc;

   mf3_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_value (req_pixel_value),
      .req_is_flush    (req_is_flush),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_desc       (push_desc)
   );

   mf3_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_desc  (push_desc),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_desc   (pop_desc)
   );

   mf3_back u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_desc          (pop_desc),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_mode_value    (rsp_mode_value),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule

### verif/mode_filter_3x3_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// mode_filter_3x3_unit_tb
// Self-checking bench for the streaming 3x3 mode filter. A bit-accurate
// predictor of the line stores, window and frame counters runs on every
// accepted item and queues the expected mode. A checker compares each
// result against the oldest queued one. Directed frames cover pixel
// extremes, flushes inside a frame, pixels after a frame, zero and
// over-range sizes and size changes in mid-frame. Random frames of small
// sizes follow, with random gaps on both sides.
// ============================================================================
module mode_filter_3x3_unit_tb;
   import mf3_pkg::*;

   localparam int CLOCK_HIGH    = 4;
   localparam int CLOCK_LOW     = 4;
   localparam int RESET_CYCLES  = 10;
   localparam int CYCLE_LIMIT   = 100000;
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_ITEMS  = 1100;
   localparam int MAX_REPORTS   = 100;

   typedef struct {
      pixel_type mode_value;
      logic      last_of_frame;
   } mode_result_type;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      csr_wr_en   = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index   = CSR_FRAME_WIDTH;
   cfg_type                   csr_wr_data = '0;
   logic                      req_valid   = 1'b0;
   logic                      req_ready;
   pixel_type                 req_pixel_value = '0;
   logic                      req_is_flush    = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready   = 1'b0;
   pixel_type                 rsp_mode_value;
   logic                      rsp_last_of_frame;

   // predictor state
   cfg_type         width_reg  = cfg_type'(WIDTH_RESET);
   cfg_type         height_reg = cfg_type'(HEIGHT_RESET);
   pixel_type       above_line   [MAX_WIDTH] = '{default: '0};
   pixel_type       current_line [MAX_WIDTH] = '{default: '0};
   pixel_type       window [WIN_TAPS] = '{default: '0};
   int unsigned     col_pos = 0;
   int unsigned     row_pos = 0;
   mode_result_type pending_modes [$];

   int          fail_count  = 0;
   int          cycle_count = 0;
   int unsigned items_sent  = 0;
   bit          send_gaps   = 1'b1;
   bit          recv_gaps   = 1'b1;

   mode_filter_3x3_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_pixel_value   (req_pixel_value),
      .req_is_flush      (req_is_flush),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_mode_value    (rsp_mode_value),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

   always begin
      #CLOCK_LOW clock = 1'b1;
      #CLOCK_HIGH clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("mode_filter_3x3_unit verification failed");
         $finish;
      end
   end

   function automatic void shift_window(pixel_type a, pixel_type b, pixel_type n);
      pixel_type col [3];
      col[0] = a;
      col[1] = b;
      col[2] = n;
      for (int r = 0; r < 3; r++) begin
         window[r * 3 + 0] = window[r * 3 + 1];
         window[r * 3 + 1] = window[r * 3 + 2];
         window[r * 3 + 2] = col[r];
      end
   endfunction

   // mode of the window built from three window columns, edges repeated
   function automatic pixel_type clamped_mode(int cl, int cm, int cr,
                                              int unsigned r, int unsigned h);
      pixel_type   taps [WIN_TAPS];
      int          cols [3];
      pixel_type   best_val;
      int unsigned best_cnt;
      int unsigned cnt;
      cols[0] = cl;
      cols[1] = cm;
      cols[2] = cr;
      for (int k = 0; k < 3; k++) begin
         taps[k]     = (r == 0) ? window[3 + cols[k]] : window[cols[k]];
         taps[3 + k] = window[3 + cols[k]];
         taps[6 + k] = (r + 1 >= h) ? window[3 + cols[k]] : window[6 + cols[k]];
      end
      best_val = '0;
      best_cnt = 0;
      for (int i = 0; i < WIN_TAPS; i++) begin
         cnt = 0;
         for (int j = 0; j < WIN_TAPS; j++)
            if (taps[j] == taps[i])
               cnt++;
         if (cnt > best_cnt || (cnt == best_cnt && taps[i] < best_val)) begin
            best_cnt = cnt;
            best_val = taps[i];
         end
      end
      return best_val;
   endfunction

   function automatic void filter_step(pixel_type pix, logic flush);
      int unsigned w, h, t, r, c;
      pixel_type   v, a, b, mode_v;
      logic        emit, last;
      w = 32'(width_reg);
      h = 32'(height_reg);
      if (w == 0) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      if (h == 0) h = 1;
      if (h > HEIGHT_CAP) h = HEIGHT_CAP;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      t = row_pos * w + col_pos;
      if (row_pos > h + 1 || t > w * h + w) begin
         row_pos = 0;
         col_pos = 0;
         t = 0;
      end
      c = col_pos;
      v = flush ? pixel_type'(0) : pix;
      a = above_line[c];
      b = current_line[c];
      above_line[c]   = b;
      current_line[c] = v;
      emit   = (t >= w + 1) && (t <= w * h + w);
      mode_v = '0;
      if (c == 0) begin
         r = (row_pos >= 2) ? row_pos - 2 : 0;
         if (emit)
            mode_v = (w == 1) ? clamped_mode(2, 2, 2, r, h) : clamped_mode(1, 2, 2, r, h);
         shift_window(a, b, v);
      end else begin
         r = (row_pos == 0) ? 0 : row_pos - 1;
         shift_window(a, b, v);
         if (emit)
            mode_v = (c == 1) ? clamped_mode(1, 1, 2, r, h) : clamped_mode(0, 1, 2, r, h);
      end
      last = emit && (t == w * h + w);
      if (last) begin
         col_pos = 0;
         row_pos = 0;
      end else begin
         col_pos++;
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
         end
      end
      if (emit)
         pending_modes.push_back('{mode_value: mode_v, last_of_frame: last});
   endfunction

   // result side: random stalls, checks every accepted item
   initial begin
      int unsigned stall;
      forever begin
         stall = recv_gaps ? $urandom_range(0, 4) : 0;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_ready));
      end
   end

   always @(posedge clock) begin
      mode_result_type exp_res;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_modes.size() == 0) begin
            if (fail_count < MAX_REPORTS)
               $error("unexpected item: mode_value %0d last_of_frame %0d",
                      rsp_mode_value, rsp_last_of_frame);
            fail_count++;
         end else begin
            exp_res = pending_modes.pop_front();
            if (rsp_mode_value !== exp_res.mode_value) begin
               if (fail_count < MAX_REPORTS)
                  $error("mode_value expected %0d actual %0d",
                         exp_res.mode_value, rsp_mode_value);
               fail_count++;
            end
            if (rsp_last_of_frame !== exp_res.last_of_frame) begin
               if (fail_count < MAX_REPORTS)
                  $error("last_of_frame expected %0d actual %0d",
                         exp_res.last_of_frame, rsp_last_of_frame);
               fail_count++;
            end
         end
      end
   end

   task automatic send_item(pixel_type pix, logic flush);
      int unsigned gap;
      gap = send_gaps ? $urandom_range(0, 4) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel_value <= pix;
      req_is_flush    <= flush;
      do @(posedge clock); while (req_ready !== 1'b1);
      filter_step(pix, flush);
      items_sent++;
   endtask

   // hold the sender until every expected result is in and the pipe is empty
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_modes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] index, cfg_type data);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      if (index == CSR_FRAME_WIDTH)
         width_reg = data;
      else
         height_reg = data;
   endtask

   task automatic set_frame(cfg_type w, cfg_type h);
      settle();
      write_reg(CSR_FRAME_WIDTH, w);
      write_reg(CSR_FRAME_HEIGHT, h);
   endtask

   // drain items until the frame closes; some are pixels, which act as flushes
   task automatic drain_frame();
      while (!(col_pos == 0 && row_pos == 0))
         send_item(pixel_type'($urandom_range(0, 1023)), $urandom_range(0, 3) != 0);
   endtask

   task automatic test_directed_frames();
      pixel_type dir_pix   [9] = '{10'h3FF, 10'h000, 10'h2AA, 10'h155, 10'h3FF,
                                   10'h3FF, 10'h155, 10'h2AA, 10'h000};
      logic      dir_flush [9] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                                   1'b0, 1'b0, 1'b0, 1'b0};
      set_frame(3, 3);
      for (int i = 0; i < 9; i++)
         send_item(dir_pix[i], dir_flush[i]);
      drain_frame();
      // zero sizes act as one
      set_frame(0, 0);
      send_item(10'h3FF, 1'b0);
      drain_frame();
   endtask

   task automatic test_size_change_mid_frame();
      set_frame(4, 3);
      repeat (6) send_item(pixel_type'($urandom_range(0, 3)), 1'b0);
      settle();
      write_reg(CSR_FRAME_WIDTH, 2);
      drain_frame();
      // shrink the height so the position lies beyond the drain
      set_frame(4, 3);
      repeat (10) send_item(pixel_type'($urandom_range(0, 3)), 1'b0);
      settle();
      write_reg(CSR_FRAME_HEIGHT, 1);
      drain_frame();
   endtask

   // largest register values, then a small frame picks up the position
   task automatic test_over_range_sizes();
      set_frame(cfg_type'('1), cfg_type'('1));
      repeat (5) send_item(pixel_type'($urandom_range(0, 1023)), 1'b0);
      settle();
      write_reg(CSR_FRAME_WIDTH, cfg_type'(3));
      write_reg(CSR_FRAME_HEIGHT, cfg_type'(2));
      drain_frame();
   endtask

   task automatic test_random_frames();
      int unsigned w_cfg, h_cfg, w_eff, h_eff, n_pix, start_count;
      pixel_type   palette [4];
      bit          use_palette;
      start_count = items_sent;
      w_cfg = 5;
      h_cfg = 3;
      while (items_sent - start_count < RANDOM_ITEMS) begin
         if ($urandom_range(0, 2) == 0 || items_sent == start_count) begin
            case ($urandom_range(0, 9))
               0:       w_cfg = 0;
               1:       w_cfg = $urandom_range(11, 40);
               default: w_cfg = $urandom_range(1, 10);
            endcase
            h_cfg = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
            set_frame(cfg_type'(w_cfg), cfg_type'(h_cfg));
         end
         send_gaps = $urandom_range(0, 3) != 0;
         recv_gaps = $urandom_range(0, 3) != 0;
         w_eff = (w_cfg == 0) ? 1 : w_cfg;
         h_eff = (h_cfg == 0) ? 1 : h_cfg;
         foreach (palette[i])
            palette[i] = pixel_type'($urandom_range(0, 1023));
         use_palette = $urandom_range(0, 3) != 0;
         n_pix = ($urandom_range(0, 7) == 0) ? $urandom_range(0, w_eff * h_eff)
                                            : w_eff * h_eff;
         for (int i = 0; i < n_pix; i++)
            send_item(use_palette ? palette[$urandom_range(0, 3)]
                                  : pixel_type'($urandom_range(0, 1023)),
                      $urandom_range(0, 31) == 0);
         drain_frame();
      end
      send_gaps = 1'b1;
      recv_gaps = 1'b1;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_directed_frames();
      test_size_change_mid_frame();
      test_over_range_sizes();
      test_random_frames();
      settle();
      if (fail_count == 0 && pending_modes.size() == 0) begin
         $display("mode_filter_3x3_unit verification clean");
      end else begin
         $display("mode_filter_3x3_unit verification failed");
      end
      $finish;
   end

endmodule
